@@ hdl/stt_pkg.sv @@
// Shared types and constants for the strip to triangle list converter.
package stt_pkg;

    localparam int unsigned IDX_W = 16;
    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
    localparam logic [IDX_W-1:0] RESTART_RESET = 16'hFFFF;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             end_of_list;
    } in_word_t;

    typedef struct packed {
        logic             tri_valid;
        logic [IDX_W-1:0] vertex_a;
        logic [IDX_W-1:0] vertex_b;
        logic [IDX_W-1:0] vertex_c;
        logic [CNT_W-1:0] strip_total;
        logic [CNT_W-1:0] dropped_total;
    } out_word_t;

    // Classified word handed from the strip tracker to the output side.
    typedef struct packed {
        logic             emit;
        logic             odd;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [IDX_W-1:0] idx_c;
        logic [CNT_W-1:0] strip_total;
        logic [CNT_W-1:0] dropped_total;
    } cmd_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

@@ hdl/stt_front.sv @@
// Strip tracker: holds the last two indices, classifies each word, keeps the counts.
module stt_front #(
    parameter int unsigned INDEX_WIDTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr,
    input  logic [stt_pkg::IDX_W-1:0]  cfg_data,
    input  logic                       in_push,
    input  stt_pkg::in_word_t          in_word,
    output stt_pkg::cmd_t              cmd
);
    import stt_pkg::*;

    localparam int unsigned EXT_W = INDEX_WIDTH + IDX_W;

    logic [IDX_W-1:0]       restart_reg;
    logic [INDEX_WIDTH-1:0] older_reg, older_next;
    logic [INDEX_WIDTH-1:0] newer_reg, newer_next;
    logic [1:0]             fill_reg, fill_next;
    logic                   odd_reg, odd_next;
    logic [CNT_W-1:0]       strip_cnt_reg, strip_cnt_next;
    logic [CNT_W-1:0]       drop_cnt_reg, drop_cnt_next;

    logic [EXT_W-1:0]       v_ext, rs_ext, a_ext, b_ext, c_ext;
    logic [INDEX_WIDTH-1:0] v_idx, rs_idx;
    logic                   is_restart, has_tri, degen;
    logic [CNT_W-1:0]       strip_upd, drop_upd;

    // Compare within INDEX_WIDTH bits
    assign v_ext  = {{INDEX_WIDTH{1'b0}}, in_word.vertex_index};
    assign rs_ext = {{INDEX_WIDTH{1'b0}}, restart_reg};
    assign v_idx  = v_ext[INDEX_WIDTH-1:0];
    assign rs_idx = rs_ext[INDEX_WIDTH-1:0];

    assign is_restart = (v_idx == rs_idx);
    assign has_tri    = !is_restart && (fill_reg >= 2'd2);
    assign degen      = (older_reg == newer_reg) || (newer_reg == v_idx)
                        || (older_reg == v_idx);

    assign strip_upd = (has_tri && fill_reg == 2'd2) ? sat_inc(strip_cnt_reg)
                                                     : strip_cnt_reg;
    assign drop_upd  = (has_tri && degen) ? sat_inc(drop_cnt_reg) : drop_cnt_reg;

    assign a_ext = {{IDX_W{1'b0}}, older_reg};
    assign b_ext = {{IDX_W{1'b0}}, newer_reg};
    assign c_ext = {{IDX_W{1'b0}}, v_idx};

    always_comb begin
        cmd.emit          = has_tri && !degen;
        cmd.odd           = odd_reg;
        cmd.idx_a         = a_ext[IDX_W-1:0];
        cmd.idx_b         = b_ext[IDX_W-1:0];
        cmd.idx_c         = c_ext[IDX_W-1:0];
        cmd.strip_total   = strip_upd;
        cmd.dropped_total = drop_upd;
    end

    always_comb begin
        older_next     = older_reg;
        newer_next     = newer_reg;
        fill_next      = fill_reg;
        odd_next       = odd_reg;
        strip_cnt_next = strip_cnt_reg;
        drop_cnt_next  = drop_cnt_reg;
        if (in_push) begin
            if (is_restart) begin
                fill_next = 2'd0;
                odd_next  = 1'b0;
            end else begin
                if (fill_reg >= 2'd2) begin
                    fill_next = 2'd3;
                    odd_next  = !odd_reg;
                end else begin
                    fill_next = fill_reg + 2'd1;
                end
                older_next = newer_reg;
                newer_next = v_idx;
            end
            strip_cnt_next = strip_upd;
            drop_cnt_next  = drop_upd;
            // Drop all strip state after the last word of a list
            if (in_word.end_of_list) begin
                older_next     = '0;
                newer_next     = '0;
                fill_next      = 2'd0;
                odd_next       = 1'b0;
                strip_cnt_next = '0;
                drop_cnt_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restart_reg   <= RESTART_RESET;
            older_reg     <= '0;
            newer_reg     <= '0;
            fill_reg      <= 2'd0;
            odd_reg       <= 1'b0;
            strip_cnt_reg <= '0;
            drop_cnt_reg  <= '0;
        end else begin
            if (cfg_wr) begin
                restart_reg <= cfg_data;
            end
            older_reg     <= older_next;
            newer_reg     <= newer_next;
            fill_reg      <= fill_next;
            odd_reg       <= odd_next;
            strip_cnt_reg <= strip_cnt_next;
            drop_cnt_reg  <= drop_cnt_next;
        end
    end

    a_counted_strip: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'd3) |-> (strip_cnt_reg != '0))
        else $error("strip in progress but strip count is zero");

    a_odd_in_strip: assert property (@(posedge aclk) disable iff (!aresetn)
        odd_reg |-> (fill_reg == 2'd3))
        else $error("odd parity outside a counted strip");

    a_drop_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (drop_cnt_reg != '0 && $past(aresetn)) |->
            (drop_cnt_reg == $past(drop_cnt_reg)
             || drop_cnt_reg == $past(drop_cnt_reg) + 1'b1))
        else $error("drop count moved by more than one");

endmodule

@@ hdl/stt_back.sv @@
// Output side: short queue of classified words, winding swap and output register.
module stt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_push,
    input  stt_pkg::cmd_t       q_cmd,
    output logic                q_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output stt_pkg::out_word_t  m_data
);
    import stt_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNTQ_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNTQ_W-1:0] DEPTH_C = CNTQ_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTQ_W-1:0] count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_reg, out_next;
    cmd_t              head;
    logic              q_pop;

    assign q_ready = (count_reg != DEPTH_C);
    assign head    = queue_mem[rd_ptr_reg];
    assign q_pop   = (count_reg != '0) && (!out_valid_reg || m_ready);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (q_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNTQ_W'(q_push) - CNTQ_W'(q_pop);
    end

    // Apply the winding swap and zero the vertices of a word with no triangle
    always_comb begin
        out_next                = out_reg;
        out_valid_next          = out_valid_reg && !m_ready;
        if (q_pop) begin
            out_valid_next          = 1'b1;
            out_next.tri_valid      = head.emit;
            out_next.vertex_a       = head.emit ? head.idx_a : '0;
            out_next.vertex_b       = !head.emit ? '0 : (head.odd ? head.idx_c : head.idx_b);
            out_next.vertex_c       = !head.emit ? '0 : (head.odd ? head.idx_b : head.idx_c);
            out_next.strip_total    = head.strip_total;
            out_next.dropped_total  = head.dropped_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            queue_mem[wr_ptr_reg] <= q_cmd;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (count_reg != DEPTH_C))
        else $error("push into full queue");

    a_empty_vertices: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.tri_valid) |->
            (m_data.vertex_a == '0 && m_data.vertex_b == '0 && m_data.vertex_c == '0))
        else $error("vertices set on a word with no triangle");

    a_out_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("output word dropped without being taken");

endmodule

@@ hdl/strip_to_triangle_list.sv @@
// Top level of the triangle strip to triangle list converter.
// Usage:
//   s_valid/s_ready/s_data carry one vertex index word (index plus end-of-list
//   flag). m_valid/m_ready/m_data return exactly one result word per input word:
//   the triangle (if any, winding corrected), plus the saturating strip count
//   and dropped-triangle count. cfg_valid/cfg_ready/cfg_data write the restart
//   index; write it only while no words are in flight. cfg_ready is always high.
//   Throughput: one word per cycle while s_ready is high; the strip tracker
//   updates the last-two-index window as each word is accepted.
//   Path: the tracker writes each accepted word into a two-entry queue, and
//   the word moves from the queue into the output register that drives m_valid
//   once that register is empty or its word is being taken.
//   Stall: when m_ready is low the queue fills; s_ready drops once it holds two
//   words. The output word holds steady until taken.
//   Reset (aresetn low, synchronous): clears the window, parity, counts and the
//   queue, and sets the restart index to 0xFFFF.
//   INDEX_WIDTH sets how many index bits are stored and compared.
module strip_to_triangle_list #(
    parameter int unsigned INDEX_WIDTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [stt_pkg::IDX_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  stt_pkg::in_word_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output stt_pkg::out_word_t         m_data
);
    import stt_pkg::*;

    cmd_t cmd;
    logic q_ready;
    logic push;

    assign cfg_ready = 1'b1;
    assign s_ready   = q_ready;
    assign push      = s_valid && q_ready;

    stt_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_valid),
        .cfg_data (cfg_data),
        .in_push  (push),
        .in_word  (s_data),
        .cmd      (cmd)
    );

    stt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (push),
        .q_cmd   (cmd),
        .q_ready (q_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ sim/tb_strip_to_triangle_list.sv @@
// Testbench for the strip to triangle list converter: predicts each result word and checks it.
`timescale 1ns / 100ps

module tb_strip_to_triangle_list;
    import stt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int REPORT_LIMIT   = 10;

    // Tracks the strip window and counts; each accepted index yields one due output word.
    class tri_scoreboard;
        logic [IDX_W-1:0] restart;
        logic [IDX_W-1:0] older;
        logic [IDX_W-1:0] newer;
        logic [1:0]       fill;
        logic             odd;
        logic [CNT_W-1:0] strips;
        logic [CNT_W-1:0] drops;
        out_word_t        due_outputs[$];
        int               mismatches;

        function new();
            restart    = RESTART_RESET;
            mismatches = 0;
            clear_run();
        endfunction

        function void clear_run();
            older  = '0;
            newer  = '0;
            fill   = '0;
            odd    = 1'b0;
            strips = '0;
            drops  = '0;
        endfunction

        function void assemble(in_word_t w);
            out_word_t        exp;
            logic [IDX_W-1:0] c;
            exp = '0;
            c   = w.vertex_index;
            if (c == restart) begin
                fill = '0;
                odd  = 1'b0;
            end else begin
                if (fill >= 2'd2) begin
                    // count the strip once, on its third index
                    if (fill == 2'd2) begin
                        strips = (strips == CNT_MAX) ? strips : strips + 1'b1;
                        fill   = 2'd3;
                    end
                    if (older == newer || newer == c || older == c) begin
                        drops = (drops == CNT_MAX) ? drops : drops + 1'b1;
                    end else begin
                        exp.tri_valid = 1'b1;
                        exp.vertex_a  = older;
                        exp.vertex_b  = odd ? c : newer;
                        exp.vertex_c  = odd ? newer : c;
                    end
                    odd = ~odd;
                end else begin
                    fill = fill + 1'b1;
                end
                older = newer;
                newer = c;
            end
            exp.strip_total   = strips;
            exp.dropped_total = drops;
            due_outputs.insert(due_outputs.size(), exp);
            if (w.end_of_list)
                clear_run();
        endfunction

        function void compare_output(out_word_t got);
            out_word_t exp;
            if (due_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: tri=%0d a=%h b=%h c=%h strips=%0d drops=%0d",
                             got.tri_valid, got.vertex_a, got.vertex_b, got.vertex_c,
                             got.strip_total, got.dropped_total);
                return;
            end
            exp = due_outputs.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch: exp tri=%0d a=%h b=%h c=%h strips=%0d drops=%0d",
                             exp.tri_valid, exp.vertex_a, exp.vertex_b, exp.vertex_c,
                             exp.strip_total, exp.dropped_total);
                    $display("          got tri=%0d a=%h b=%h c=%h strips=%0d drops=%0d",
                             got.tri_valid, got.vertex_a, got.vertex_b, got.vertex_c,
                             got.strip_total, got.dropped_total);
                end
            end
        endfunction
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_data  = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_word_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_word_t        m_data;

    tri_scoreboard    sb;
    int               idle_pct  = 0;
    int               stall_pct = 0;
    int               quiet_cycles = 0;
    logic [IDX_W-1:0] restart_value = RESTART_RESET;

    strip_to_triangle_list dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Sample handshakes on the edge; inputs change only by nonblocking drives.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.assemble(s_data);
            if (m_valid && m_ready)
                sb.compare_output(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [IDX_W-1:0] idx, input logic eol);
        in_word_t w;
        w.vertex_index = idx;
        w.end_of_list  = eol;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Hold the sender until every due word is back, then let the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.due_outputs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_restart(input logic [IDX_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid     <= 1'b0;
        sb.restart     = value;
        restart_value  = value;
    endtask

    // Mostly strips of random length; narrow index pools make degenerate triangles common.
    task automatic random_strips(input int n_words);
        int               sent;
        int               len;
        int               ending;
        bit               narrow;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] idx;
        sent = 0;
        while (sent < n_words) begin
            len    = $urandom_range(0, 10);
            narrow = $urandom_range(0, 1);
            base   = IDX_W'($urandom);
            for (int i = 0; i < len; i++) begin
                idx = narrow ? base + IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom);
                send_word(idx, $urandom_range(0, 39) == 0);
                sent++;
            end
            ending = $urandom_range(0, 3);
            if (ending < 2) begin
                send_word(restart_value, $urandom_range(0, 7) == 0);
                sent++;
            end else if (ending == 3) begin
                send_word(restart_value, 1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default restart value
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFE, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'h0002, 1'b0);
        send_word(16'h0002, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'h1234, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0003, 1'b0);
        send_word(16'h0004, 1'b1);
        send_word(16'h0010, 1'b0);
        send_word(16'h0020, 1'b0);
        send_word(16'h0030, 1'b1);

        // directed: zero restart makes all-ones a plain vertex
        write_restart(16'h0000);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0001, 1'b1);

        write_restart(IDX_W'($urandom));
        random_strips(420);

        write_restart(16'hFFFF);
        idle_pct  = 73;
        stall_pct = 0;
        random_strips(410);

        write_restart(16'h0000);
        idle_pct  = 0;
        stall_pct = 73;
        random_strips(410);

        write_restart(IDX_W'($urandom));
        idle_pct  = 37;
        stall_pct = 37;
        random_strips(410);

        drain();
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.due_outputs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
